### rtl/core/atc_pkg.sv
// types, step codes and control store for the adjacency tree check
package atc_pkg;

  typedef logic [2:0] step_t;

  localparam step_t S_IDLE = 3'd0;
  localparam step_t S_READ = 3'd1;
  localparam step_t S_SCAN = 3'd2;
  localparam step_t S_POP  = 3'd3;
  localparam step_t S_DONE = 3'd4;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  localparam logic [4:0] VCOUNT_RST = 5'd16;

  typedef struct packed {
    logic  wait_start;
    logic  rd_row;
    logic  scan;
    logic  pop_ld;
    logic  emit;
    step_t nxt;
    step_t br_a;
    step_t br_b;
    step_t br_c;
  } ctrl_t;

  function automatic ctrl_t ucode_rom(input step_t s);
    ctrl_t w;
    w = '0;
    case (s)
      S_IDLE: begin
        w.wait_start = 1'b1;
        w.nxt        = S_IDLE;
        w.br_a       = S_READ;
      end
      S_READ: begin
        w.rd_row = 1'b1;
        w.nxt    = S_SCAN;
      end
      S_SCAN: begin
        w.scan = 1'b1;
        w.nxt  = S_SCAN;
        w.br_a = S_READ;
        w.br_b = S_POP;
        w.br_c = S_DONE;
      end
      S_POP: begin
        w.pop_ld = 1'b1;
        w.nxt    = S_READ;
      end
      S_DONE: begin
        w.emit = 1'b1;
        w.nxt  = S_IDLE;
      end
      default: begin
        w.nxt = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

### rtl/core/adjacency_tree_check.sv
// adjacency tree check: row loads and a microcoded depth-first tree walk
// a row load is written when it is taken; a check strobes its verdict when the walk ends,
// which is earlier when the walk fails early or reaches fewer vertices than the vertex count
// the walk scans one matrix cell per cycle in the scan step; a descent goes through a row read
// step, a return through a pop and a row read step; one transaction at a time,
// loads back to back; busy is high from the cycle after a check is taken and drops as the
// verdict strobes; the verdict is shown for one cycle on out_valid; the receiver cannot stall
// synchronous active-low reset clears the sequencer and sets vertex count to 16
module adjacency_tree_check #(
  parameter int MAX_VERTICES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [3:0]  in_row_index,
  input  logic [15:0] in_row_bits,
  output logic        out_valid,
  output logic        out_is_tree,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_data
);
  import atc_pkg::*;

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);

  typedef struct packed {
    logic [VW-1:0] vtx;
    logic [VW-1:0] par;
    logic          has_par;
    logic [CW-1:0] col;
  } frame_t;

  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  frame_t                  stk_mem [MAX_VERTICES];

  step_t                   step_r;
  step_t                   step_nxt;
  ctrl_t                   cw;
  logic [4:0]              vcount_r;
  logic [CW-1:0]           n_use;
  logic [MAX_VERTICES-1:0] need_mask;
  logic [MAX_VERTICES-1:0] visited_r;
  logic [MAX_VERTICES-1:0] row_r;
  logic [VW-1:0]           sp_r;
  frame_t                  cur_r;
  frame_t                  stk_rd_r;
  logic                    ok_r;
  logic                    out_valid_r;
  logic                    out_is_tree_r;

  logic                    accept;
  logic                    wr_en;
  logic [VW-1:0]           wr_addr;
  logic [VW-1:0]           cidx;
  logic                    col_end;
  logic                    edge_bit;
  logic                    seen;
  logic                    is_par;
  logic                    do_push;
  logic                    do_pop;
  logic                    do_fail;
  logic                    do_finish;
  frame_t                  push_frame;

  assign cw      = ucode_rom(step_r);
  assign busy    = (step_r != S_IDLE);
  assign accept  = start && !busy;
  assign wr_en   = accept && (in_op == OP_LOAD) && (int'(in_row_index) < MAX_VERTICES);
  assign wr_addr = VW'(in_row_index);

  always_comb begin
    if (vcount_r == 5'd0) begin
      n_use = CW'(1);
    end else if (int'(vcount_r) > MAX_VERTICES) begin
      n_use = CW'(MAX_VERTICES);
    end else begin
      n_use = CW'(vcount_r);
    end
    for (int i = 0; i < MAX_VERTICES; i++) begin
      need_mask[i] = (i < int'(n_use));
    end
  end

  assign cidx      = cur_r.col[VW-1:0];
  assign col_end   = (cur_r.col >= n_use);
  assign edge_bit  = row_r[cidx];
  assign seen      = visited_r[cidx];
  assign is_par    = cur_r.has_par && (cur_r.par == cidx);
  assign do_push   = cw.scan && !col_end && edge_bit && !seen;
  assign do_fail   = cw.scan && !col_end && edge_bit && seen && !is_par;
  assign do_pop    = cw.scan && col_end && (sp_r != '0);
  assign do_finish = do_fail || (cw.scan && col_end && (sp_r == '0));

  always_comb begin
    push_frame     = cur_r;
    push_frame.col = cur_r.col + CW'(1);
  end

  always_comb begin
    step_nxt = cw.nxt;
    if (cw.wait_start && accept && (in_op == OP_CHECK)) begin
      step_nxt = cw.br_a;
    end else if (do_push) begin
      step_nxt = cw.br_a;
    end else if (do_pop) begin
      step_nxt = cw.br_b;
    end else if (do_finish) begin
      step_nxt = cw.br_c;
    end
  end

  // adjacency rows
  always_ff @(posedge clk) begin
    if (wr_en) begin
      adj_mem[wr_addr] <= MAX_VERTICES'(in_row_bits);
    end
    if (cw.rd_row) begin
      row_r <= adj_mem[cur_r.vtx];
    end
  end

  // saved walk frames
  always_ff @(posedge clk) begin
    if (do_push) begin
      stk_mem[sp_r] <= push_frame;
    end
    if (do_pop) begin
      stk_rd_r <= stk_mem[sp_r - VW'(1)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r        <= S_IDLE;
      vcount_r      <= VCOUNT_RST;
      visited_r     <= '0;
      sp_r          <= '0;
      ok_r          <= 1'b0;
      out_valid_r   <= 1'b0;
      out_is_tree_r <= 1'b0;
      cur_r         <= '0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        vcount_r <= cfg_data;
      end
      if (cw.wait_start && accept && (in_op == OP_CHECK)) begin
        visited_r <= MAX_VERTICES'(1);
        sp_r      <= '0;
        ok_r      <= 1'b1;
        cur_r     <= '0;
      end
      if (cw.scan && !col_end && !do_push) begin
        cur_r.col <= push_frame.col;
      end
      if (do_push) begin
        visited_r[cidx] <= 1'b1;
        sp_r            <= sp_r + VW'(1);
        cur_r.vtx       <= cidx;
        cur_r.par       <= cur_r.vtx;
        cur_r.has_par   <= 1'b1;
        cur_r.col       <= '0;
      end
      if (do_fail) begin
        ok_r <= 1'b0;
      end
      if (do_pop) begin
        sp_r <= sp_r - VW'(1);
      end
      if (cw.pop_ld) begin
        cur_r <= stk_rd_r;
      end
      if (cw.emit) begin
        out_valid_r   <= 1'b1;
        out_is_tree_r <= ok_r && ((visited_r & need_mask) == need_mask);
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_is_tree = out_is_tree_r;

endmodule

### sim/adjacency_tree_check_tb.sv
// testbench for adjacency_tree_check: random tree loads and checks against an internal walk model
module adjacency_tree_check_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import atc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic        op;
    logic [3:0]  row;
    logic [15:0] bits;
  } graph_cmd_t;

  typedef enum int {
    FLAW_NONE, FLAW_CYCLE, FLAW_CUT, FLAW_LOOP, FLAW_ONEWAY, FLAW_HIGH, FLAW_STALE
  } flaw_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_op = 1'b0;
  logic [3:0]  in_row_index = 4'd0;
  logic [15:0] in_row_bits = 16'd0;
  logic        out_valid;
  logic        out_is_tree;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_data = 5'd0;

  graph_cmd_t  graph_cmds [$];
  logic        verdicts_due [$];
  logic [15:0] model_rows [16];
  logic [4:0]  vertex_cfg = VCOUNT_RST;
  graph_cmd_t  next_cmd;
  logic        want_tree;
  int          hold_off = 0;
  int          fail_count = 0;
  int          cycle_count = 0;
  int          issued = 0;
  bit          idle_on = 1'b1;

  adjacency_tree_check dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_op        (in_op),
    .in_row_index (in_row_index),
    .in_row_bits  (in_row_bits),
    .out_valid    (out_valid),
    .out_is_tree  (out_is_tree),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int eff_count(input logic [4:0] v);
    if (v < 5'd1) return 1;
    if (v > 5'd16) return 16;
    return int'(v);
  endfunction

  function automatic int draw_gap();
    return idle_on ? $urandom_range(0, 13) : 0;
  endfunction

  // depth-first walk from vertex 0 over the model rows
  function automatic logic tree_verdict();
    int          n;
    int          depth;
    int          c;
    int          u;
    logic        ok;
    logic [15:0] seen;
    logic [16:0] full;
    int          stk_v [16];
    int          stk_p [16];
    bit          stk_hp [16];
    int          stk_c [16];
    n = eff_count(vertex_cfg);
    ok = 1'b1;
    seen = 16'h0001;
    depth = 1;
    stk_v[0] = 0;
    stk_p[0] = 0;
    stk_hp[0] = 1'b0;
    stk_c[0] = 0;
    while (ok && depth > 0) begin
      c = stk_c[depth-1];
      u = stk_v[depth-1];
      if (c >= n) begin
        depth--;
      end else begin
        stk_c[depth-1] = c + 1;
        if (model_rows[u][c]) begin
          if (!seen[c]) begin
            if (depth < 16) begin
              stk_v[depth] = c;
              stk_p[depth] = u;
              stk_hp[depth] = 1'b1;
              stk_c[depth] = 0;
              depth++;
            end
            seen[c] = 1'b1;
          end else if (!(stk_hp[depth-1] && stk_p[depth-1] == c)) begin
            ok = 1'b0;
          end
        end
      end
    end
    full = (17'd1 << n) - 17'd1;
    if (ok && ((seen & full[15:0]) != full[15:0])) ok = 1'b0;
    return ok;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      hold_off <= 0;
    end else begin
      if (start && !busy) begin
        if (in_op == OP_LOAD) model_rows[in_row_index] = in_row_bits;
        else verdicts_due.push_back(tree_verdict());
      end
      if (!(start && busy)) begin
        if (hold_off != 0) begin
          start <= 1'b0;
          hold_off <= hold_off - 1;
        end else if (graph_cmds.size() != 0) begin
          next_cmd = graph_cmds.pop_front();
          in_op <= next_cmd.op;
          in_row_index <= next_cmd.row;
          in_row_bits <= next_cmd.bits;
          start <= 1'b1;
          hold_off <= draw_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (verdicts_due.size() == 0) begin
        $error("is_tree: no transaction expected, actual %0d", out_is_tree);
        fail_count++;
      end else begin
        want_tree = verdicts_due.pop_front();
        if (out_is_tree !== want_tree) begin
          $error("is_tree: expected %0d actual %0d", want_tree, out_is_tree);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("adjacency_tree_check test failed");
      $finish;
    end
  end

  task automatic push_cmd(input logic op, input logic [3:0] row, input logic [15:0] bits);
    graph_cmd_t c;
    c.op = op;
    c.row = row;
    c.bits = bits;
    graph_cmds.push_back(c);
    issued++;
  endtask

  task automatic push_check();
    push_cmd(OP_CHECK, 4'($urandom), 16'($urandom));
  endtask

  task automatic settle();
    @(negedge clk);
    while (graph_cmds.size() != 0 || start || busy || verdicts_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_vertex_count(input logic [4:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    vertex_cfg = v;
  endtask

  task automatic queue_tree_case(input int n, input flaw_t flaw);
    logic [15:0] adj [16];
    int          perm [16];
    int          order [16];
    int          ea [16];
    int          eb [16];
    int          i;
    int          j;
    int          t;
    int          a;
    int          b;
    bit          junk_rows;
    logic [16:0] full;
    for (i = 0; i < 16; i++) begin
      adj[i] = 16'd0;
      perm[i] = i;
      order[i] = i;
    end
    for (i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm[i]; perm[i] = perm[j]; perm[j] = t;
    end
    for (i = 1; i < n; i++) begin
      j = $urandom_range(0, i - 1);
      ea[i] = perm[i];
      eb[i] = perm[j];
      adj[ea[i]][eb[i]] = 1'b1;
      adj[eb[i]][ea[i]] = 1'b1;
    end
    a = $urandom_range(0, n - 1);
    b = $urandom_range(0, n - 1);
    j = (n > 1) ? $urandom_range(1, n - 1) : 0;
    case (flaw)
      FLAW_CYCLE: begin
        if (a != b) begin
          adj[a][b] = 1'b1;
          adj[b][a] = 1'b1;
        end
      end
      FLAW_CUT: begin
        if (n > 1) begin
          adj[ea[j]][eb[j]] = 1'b0;
          adj[eb[j]][ea[j]] = 1'b0;
        end
      end
      FLAW_LOOP: adj[a][a] = 1'b1;
      FLAW_ONEWAY: begin
        if (n > 1 && $urandom_range(0, 1)) adj[ea[j]][eb[j]] = 1'b0;
        else adj[a][b] = ~adj[a][b];
      end
      FLAW_HIGH: begin
        full = (17'd1 << n) - 17'd1;
        for (i = 0; i < n; i++) adj[i] = adj[i] | (16'($urandom) & ~full[15:0]);
      end
      default: ;
    endcase
    junk_rows = ($urandom_range(0, 3) == 0);
    for (i = 0; i < 16; i++) begin
      if (i >= n) adj[i] = 16'($urandom);
    end
    for (i = 15; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i]; order[i] = order[j]; order[j] = t;
    end
    for (i = 0; i < 16; i++) begin
      t = order[i];
      if (t < n) begin
        if (flaw != FLAW_STALE || $urandom_range(0, 1)) push_cmd(OP_LOAD, 4'(t), adj[t]);
      end else if (junk_rows) begin
        push_cmd(OP_LOAD, 4'(t), adj[t]);
      end
    end
    push_check();
  endtask

  initial begin
    int          i;
    int          p;
    int          n;
    int          r;
    int          k;
    int          phase_end;
    logic [4:0]  cnt;
    flaw_t       flaw;
    logic [4:0]  phase_counts [8];
    phase_counts = '{5'd2, 5'd16, 5'd1, 5'd5, 5'd17, 5'd0, 5'd31, 5'd9};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // path through all sixteen vertices, then self loop, then the one-vertex cases and an over-range vertex count
    for (i = 0; i < 16; i++)
      push_cmd(OP_LOAD, 4'(i), ((i > 0) ? (16'd1 << (i - 1)) : 16'd0) |
                               ((i < 15) ? (16'd1 << (i + 1)) : 16'd0));
    push_check();
    push_cmd(OP_LOAD, 4'd0, 16'hFFFF);
    push_check();
    settle();
    write_vertex_count(5'd1);
    push_check();
    push_cmd(OP_LOAD, 4'd0, 16'h0000);
    push_check();
    settle();
    write_vertex_count(5'd0);
    push_check();
    settle();
    write_vertex_count(5'd31);
    push_check();
    settle();

    p = 0;
    while (issued < 600) begin
      cnt = (p < 8) ? phase_counts[p] : 5'($urandom_range(1, 16));
      idle_on = (p % 3 != 1);
      write_vertex_count(cnt);
      n = eff_count(cnt);
      phase_end = issued + 85;
      while (issued < phase_end) begin
        r = $urandom_range(0, 9);
        if (r < 8) begin
          if ($urandom_range(0, 1)) flaw = FLAW_NONE;
          else flaw = flaw_t'($urandom_range(1, 6));
          queue_tree_case(n, flaw);
        end else begin
          k = $urandom_range(1, 3);
          for (i = 0; i < k; i++) push_cmd(OP_LOAD, 4'($urandom), 16'($urandom));
          if ($urandom_range(0, 1)) push_check();
        end
      end
      settle();
      p++;
    end

    settle();
    if (fail_count == 0) begin
      $display("adjacency_tree_check test passed");
    end else begin
      $display("adjacency_tree_check test failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/atc_pkg.sv
rtl/core/adjacency_tree_check.sv
sim/adjacency_tree_check_tb.sv
